@@ sv/ltm_pkg.sv @@
// ----------------------------------------------------------------------------
// ltm_pkg
// Shared types and constants for the luminance tone map with gamma and clamp.
// ----------------------------------------------------------------------------
package ltm_pkg;

  localparam int COMPONENT_BITS = 16;
  localparam int FRACTION_BITS  = 8;

  // scaled channel and gamma result width (value stays below 16.0)
  localparam int SW    = FRACTION_BITS + 4;
  // L + 1 with FRACTION_BITS + 16 fraction bits
  localparam int LW    = ((COMPONENT_BITS > FRACTION_BITS) ? COMPONENT_BITS : FRACTION_BITS) + 17;
  // rounded dividend width
  localparam int DW    = COMPONENT_BITS + FRACTION_BITS + 17;
  // divider working width
  localparam int XW    = (DW > LW + SW) ? DW : LW + SW;
  // gamma target s^5 * 2^F and candidate sixth power
  localparam int TW    = 5 * SW + FRACTION_BITS;
  localparam int PW    = 6 * SW;
  // pipeline depth: luma, divider, powers, root search, clamp
  localparam int NST   = 3 * SW + 5;
  localparam int CFG_W = 3 * COMPONENT_BITS;

  localparam logic [15:0] W_RED   = 16'd13933;
  localparam logic [15:0] W_GREEN = 16'd46871;
  localparam logic [15:0] W_BLUE  = 16'd4732;

  typedef logic [COMPONENT_BITS-1:0] comp_t;

  typedef struct packed {
    comp_t red_in;
    comp_t green_in;
    comp_t blue_in;
  } pix_in_t;

  typedef struct packed {
    comp_t red_out;
    comp_t green_out;
    comp_t blue_out;
    logic  was_background;
  } pix_out_t;

  typedef enum logic [1:0] {
    CFG_BACKGROUND = 2'd0,
    CFG_MIN        = 2'd1,
    CFG_MAX        = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [NST-1:0] en;
    logic           bg_last;
  } lane_ctl_t;

endpackage

@@ sv/luminance_tone_map_gamma_clamp.sv @@
// ----------------------------------------------------------------------------
// luminance_tone_map_gamma_clamp
// Reinhard luminance tone map, 1/1.2 gamma and per-channel clamp, UQ8.8 RGB.
// ----------------------------------------------------------------------------
// Takes one pixel per clock while in_stall_o is low and returns one result
// per pixel, in order. The depth comes from the 12-step restoring divider for
// c/(L+1) and the 12 steps of the bit-by-bit root search for s^(5/6), each
// step a candidate and a compare stage; three channel lanes run in parallel.
// Empty stages close up under back-pressure, so the input is only stalled
// when every stage holds a pixel and the output is stalled. Pixels equal to
// the background color pass through with was_background set.
module luminance_tone_map_gamma_clamp import ltm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  pix_in_t          in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output pix_out_t         out_data_o,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  logic [CFG_W-1:0] bg_color_q;
  logic [CFG_W-1:0] min_color_q;
  logic [CFG_W-1:0] max_color_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bg_color_q  <= '0;
      min_color_q <= '0;
      max_color_q <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_BACKGROUND: bg_color_q  <= cfg_data_i;
        CFG_MIN:        min_color_q <= cfg_data_i;
        CFG_MAX:        max_color_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  lane_ctl_t     ctl;
  logic          bg_match;
  logic          out_bg;
  logic [LW-1:0] lq;
  comp_t         comp [3];
  comp_t         res  [3];

  ltm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .bg_i        (bg_match),
    .out_stall_i (out_stall_i),
    .in_stall_o  (in_stall_o),
    .ctl_o       (ctl),
    .out_valid_o (out_valid_o),
    .out_bg_o    (out_bg)
  );

  ltm_luma u_luma (
    .clk_i      (clk_i),
    .en_i       (ctl.en[0]),
    .pix_i      (in_data_i),
    .bg_color_i (bg_color_q),
    .bg_o       (bg_match),
    .lq_o       (lq),
    .comp_o     (comp)
  );

  for (genvar i = 0; i < 3; i++) begin : g_lane
    ltm_lane u_lane (
      .clk_i  (clk_i),
      .ctl_i  (ctl),
      .lq_i   (lq),
      .comp_i (comp[i]),
      .min_i  (min_color_q[(2-i)*COMPONENT_BITS +: COMPONENT_BITS]),
      .max_i  (max_color_q[(2-i)*COMPONENT_BITS +: COMPONENT_BITS]),
      .res_o  (res[i])
    );
  end

  always_comb begin
    out_data_o.red_out        = res[0];
    out_data_o.green_out      = res[1];
    out_data_o.blue_out       = res[2];
    out_data_o.was_background = out_bg;
  end

endmodule

@@ sv/ltm_luma.sv @@
// ----------------------------------------------------------------------------
// ltm_luma
// Front stage: background match and luminance L + 1 in fixed point.
// ----------------------------------------------------------------------------
module ltm_luma import ltm_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  pix_in_t          pix_i,
  input  logic [CFG_W-1:0] bg_color_i,
  output logic             bg_o,
  output logic [LW-1:0]    lq_o,
  output comp_t            comp_o [3]
);

  logic [LW-1:0] lq_d;
  logic [LW-1:0] lq_q;
  comp_t         comp_q [3];

  always_comb begin
    bg_o = (pix_i.red_in   == bg_color_i[2*COMPONENT_BITS +: COMPONENT_BITS]) &&
           (pix_i.green_in == bg_color_i[COMPONENT_BITS +: COMPONENT_BITS]) &&
           (pix_i.blue_in  == bg_color_i[0 +: COMPONENT_BITS]);
    lq_d = LW'(W_RED)   * LW'(pix_i.red_in) +
           LW'(W_GREEN) * LW'(pix_i.green_in) +
           LW'(W_BLUE)  * LW'(pix_i.blue_in) +
           (LW'(1) << (FRACTION_BITS + 16));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lq_q      <= lq_d;
      comp_q[0] <= pix_i.red_in;
      comp_q[1] <= pix_i.green_in;
      comp_q[2] <= pix_i.blue_in;
    end
  end

  assign lq_o   = lq_q;
  assign comp_o = comp_q;

endmodule

@@ sv/ltm_lane.sv @@
// ----------------------------------------------------------------------------
// ltm_lane
// One channel: rounded divide by L + 1, power 5/6 root search, clamp.
// ----------------------------------------------------------------------------
module ltm_lane import ltm_pkg::*; (
  input  logic          clk_i,
  input  lane_ctl_t     ctl_i,
  input  logic [LW-1:0] lq_i,
  input  comp_t         comp_i,
  input  comp_t         min_i,
  input  comp_t         max_i,
  output comp_t         res_o
);

  // divider stages
  logic [XW-1:0] dv_rem_q [SW];
  logic [SW-1:0] dv_quo_q [SW];
  logic [LW-1:0] dv_lq_q  [SW];
  comp_t         dv_c_q   [SW];

  // power stages
  logic [SW-1:0]   pw_s_q;
  logic [2*SW-1:0] pw_s2_q;
  logic [2*SW-1:0] pw_s2b_q;
  logic [3*SW-1:0] pw_s3_q;
  logic [TW-1:0]   pw_t_q;
  comp_t           pw_c_q [3];

  // root search, candidate half and compare half of each step
  logic [SW-1:0]   ga_cand_q [SW];
  logic [2*SW-1:0] ga_c2_q   [SW];
  logic [3*SW-1:0] ga_c3_q   [SW];
  logic [SW-1:0]   ga_y_q    [SW];
  logic [2*SW-1:0] ga_y2_q   [SW];
  logic [3*SW-1:0] ga_y3_q   [SW];
  logic [TW-1:0]   ga_t_q    [SW];
  comp_t           ga_c_q    [SW];

  logic [SW-1:0]   gb_y_q  [SW];
  logic [2*SW-1:0] gb_y2_q [SW];
  logic [3*SW-1:0] gb_y3_q [SW];
  logic [TW-1:0]   gb_t_q  [SW];
  comp_t           gb_c_q  [SW];

  comp_t res_q;

  for (genvar j = 0; j < SW; j++) begin : g_div
    localparam int B = SW - 1 - j;
    logic [XW-1:0] rem_in;
    logic [SW-1:0] quo_in;
    logic [LW-1:0] lq_in;
    comp_t         c_in;
    logic [XW-1:0] trial;
    logic          ge;

    if (j == 0) begin : g_first
      always_comb begin
        rem_in = XW'((DW'(comp_i) << (FRACTION_BITS + 16)) + DW'(lq_i >> 1));
        quo_in = '0;
        lq_in  = lq_i;
        c_in   = comp_i;
      end
    end else begin : g_next
      always_comb begin
        rem_in = dv_rem_q[j-1];
        quo_in = dv_quo_q[j-1];
        lq_in  = dv_lq_q[j-1];
        c_in   = dv_c_q[j-1];
      end
    end

    always_comb begin
      trial = XW'(lq_in) << B;
      ge    = (rem_in >= trial);
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.en[1+j]) begin
        dv_rem_q[j] <= ge ? rem_in - trial : rem_in;
        dv_quo_q[j] <= ge ? (quo_in | (SW'(1) << B)) : quo_in;
        dv_lq_q[j]  <= lq_in;
        dv_c_q[j]   <= c_in;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[1+SW]) begin
      pw_s_q    <= dv_quo_q[SW-1];
      pw_s2_q   <= (2*SW)'(dv_quo_q[SW-1]) * (2*SW)'(dv_quo_q[SW-1]);
      pw_c_q[0] <= dv_c_q[SW-1];
    end
    if (ctl_i.en[2+SW]) begin
      pw_s3_q   <= (3*SW)'(pw_s2_q) * (3*SW)'(pw_s_q);
      pw_s2b_q  <= pw_s2_q;
      pw_c_q[1] <= pw_c_q[0];
    end
    if (ctl_i.en[3+SW]) begin
      pw_t_q    <= TW'((5*SW)'(pw_s3_q) * (5*SW)'(pw_s2b_q)) << FRACTION_BITS;
      pw_c_q[2] <= pw_c_q[1];
    end
  end

  for (genvar k = 0; k < SW; k++) begin : g_root
    localparam int B = SW - 1 - k;
    logic [SW-1:0]   y_in;
    logic [2*SW-1:0] y2_in;
    logic [3*SW-1:0] y3_in;
    logic [TW-1:0]   t_in;
    comp_t           c_in;
    logic [SW-1:0]   cand;
    logic [2*SW-1:0] c2;
    logic [3*SW-1:0] c3;
    logic [PW-1:0]   six;
    logic            fits;

    if (k == 0) begin : g_first
      always_comb begin
        y_in  = '0;
        y2_in = '0;
        y3_in = '0;
        t_in  = pw_t_q;
        c_in  = pw_c_q[2];
      end
    end else begin : g_next
      always_comb begin
        y_in  = gb_y_q[k-1];
        y2_in = gb_y2_q[k-1];
        y3_in = gb_y3_q[k-1];
        t_in  = gb_t_q[k-1];
        c_in  = gb_c_q[k-1];
      end
    end

    // bit B of y is still clear, so (y + 2^B)^n expands into shifts
    always_comb begin
      cand = y_in | (SW'(1) << B);
      c2   = y2_in + ((2*SW)'(y_in) << (B + 1)) + ((2*SW)'(1) << (2 * B));
      c3   = y3_in + (3*SW)'(3) * ((3*SW)'(y2_in) << B) +
             (3*SW)'(3) * ((3*SW)'(y_in) << (2 * B)) + ((3*SW)'(1) << (3 * B));
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.en[4+SW+2*k]) begin
        ga_cand_q[k] <= cand;
        ga_c2_q[k]   <= c2;
        ga_c3_q[k]   <= c3;
        ga_y_q[k]    <= y_in;
        ga_y2_q[k]   <= y2_in;
        ga_y3_q[k]   <= y3_in;
        ga_t_q[k]    <= t_in;
        ga_c_q[k]    <= c_in;
      end
    end

    always_comb begin
      six  = PW'(ga_c3_q[k]) * PW'(ga_c3_q[k]);
      fits = (six <= PW'(ga_t_q[k]));
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.en[5+SW+2*k]) begin
        gb_y_q[k]  <= fits ? ga_cand_q[k] : ga_y_q[k];
        gb_y2_q[k] <= fits ? ga_c2_q[k]   : ga_y2_q[k];
        gb_y3_q[k] <= fits ? ga_c3_q[k]   : ga_y3_q[k];
        gb_t_q[k]  <= ga_t_q[k];
        gb_c_q[k]  <= ga_c_q[k];
      end
    end
  end

  logic [SW+COMPONENT_BITS-1:0] y_ext;
  comp_t                        y_sat;
  comp_t                        y_clamp;

  always_comb begin
    y_ext = (SW+COMPONENT_BITS)'(gb_y_q[SW-1]);
    y_sat = (y_ext > (SW+COMPONENT_BITS)'({COMPONENT_BITS{1'b1}})) ?
            {COMPONENT_BITS{1'b1}} : y_ext[COMPONENT_BITS-1:0];
    y_clamp = (y_sat > max_i) ? max_i : y_sat;
    if (y_clamp < min_i) begin
      y_clamp = min_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[NST-1]) begin
      res_q <= ctl_i.bg_last ? gb_c_q[SW-1] : y_clamp;
    end
  end

  assign res_o = res_q;

endmodule

@@ sv/ltm_ctrl.sv @@
// ----------------------------------------------------------------------------
// ltm_ctrl
// Per-stage valid and background tags, bubble-collapsing stage enables.
// ----------------------------------------------------------------------------
module ltm_ctrl import ltm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      bg_i,
  input  logic      out_stall_i,
  output logic      in_stall_o,
  output lane_ctl_t ctl_o,
  output logic      out_valid_o,
  output logic      out_bg_o
);

  logic [NST-1:0] vld_q, vld_d;
  logic [NST-1:0] bg_q, bg_d;
  logic [NST:0]   en;
  logic [NST-1:0] vld_prev;
  logic [NST-1:0] bg_prev;

  always_comb begin
    en[NST] = ~out_stall_i;
    for (int k = NST - 1; k >= 0; k--) begin
      en[k] = ~vld_q[k] | en[k+1];
    end
    vld_prev = {vld_q[NST-2:0], in_valid_i};
    bg_prev  = {bg_q[NST-2:0], bg_i};
    for (int k = 0; k < NST; k++) begin
      vld_d[k] = en[k] ? vld_prev[k] : vld_q[k];
      bg_d[k]  = en[k] ? bg_prev[k]  : bg_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      bg_q  <= '0;
    end else begin
      vld_q <= vld_d;
      bg_q  <= bg_d;
    end
  end

  assign in_stall_o    = ~en[0];
  assign ctl_o.en      = en[NST-1:0];
  assign ctl_o.bg_last = bg_q[NST-2];
  assign out_valid_o   = vld_q[NST-1];
  assign out_bg_o      = bg_q[NST-1];

endmodule

@@ sv/ltm_checker.sv @@
// ----------------------------------------------------------------------------
// ltm_checker
// Port-level checks for the tone map block, bound to the top level.
// ----------------------------------------------------------------------------
module ltm_checker import ltm_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input pix_out_t out_data_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // input is only held off when the output side is full and stalled
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || !out_stall_i) |-> !in_stall_o)
    else $error("request stalled while output can move");

  // nothing comes out during reset
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("result valid in reset");

endmodule

bind luminance_tone_map_gamma_clamp ltm_checker u_ltm_checker (.*);
